### hw/rtl/glct_pkg.sv
// ----------------------------------------------------------------------------
// glct_pkg
// Shared types, constants and helpers of the grid line crossing tracker.
// ----------------------------------------------------------------------------
package glct_pkg;

  localparam int NUM_GROUPS      = 4;
  localparam int GROUP_BITS      = 7;
  localparam int SAMPLE_BITS     = 16;
  localparam int OUT_POS_BITS    = 16;
  localparam int POSITION_BITS_D = 16;

  localparam logic [GROUP_BITS-1:0] EDGE_MASK  = 7'h41;
  localparam logic [GROUP_BITS-1:0] MID_MASK   = 7'h08;
  localparam logic [GROUP_BITS-1:0] INNER_MASK = 7'h3E;
  localparam logic [GROUP_BITS-1:0] FULL_MASK  = 7'h7F;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_ZERO = 16'h0000;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONES = 16'hFFFF;

  // group order: up, right, down, left
  localparam int GRP_UP    = 0;
  localparam int GRP_RIGHT = 1;
  localparam int GRP_DOWN  = 2;
  localparam int GRP_LEFT  = 3;

  localparam logic REG_GROUP_ENABLE = 1'b0;
  localparam logic [NUM_GROUPS-1:0] GROUP_ENABLE_RST = 4'h1;

  typedef enum logic [3:0] {
    PH_STANDBY = 4'b0001,
    PH_FORWARD = 4'b0010,
    PH_BACK    = 4'b0100,
    PH_END     = 4'b1000
  } phase_t;

  // what one lane reports for the current sample
  typedef struct packed {
    logic crossed;
    logic back;
  } lane_step_t;

  typedef struct packed {
    logic [OUT_POS_BITS-1:0] x_position;
    logic [OUT_POS_BITS-1:0] y_position;
    logic [NUM_GROUPS-1:0]   crossed_groups;
    logic                    sensor_fault;
  } result_t;

  function automatic logic [NUM_GROUPS*GROUP_BITS-1:0] split_groups(
    input logic [SAMPLE_BITS-1:0] s
  );
    logic [NUM_GROUPS*GROUP_BITS-1:0] g;
    g = '0;
    g[GRP_UP*GROUP_BITS    +: GROUP_BITS] = s[14:8];
    g[GRP_RIGHT*GROUP_BITS +: GROUP_BITS] = {s[2:0], s[15:12]};
    g[GRP_DOWN*GROUP_BITS  +: GROUP_BITS] = s[6:0];
    g[GRP_LEFT*GROUP_BITS  +: GROUP_BITS] = s[10:4];
    return g;
  endfunction

endpackage

### hw/rtl/glct_lane.sv
// ----------------------------------------------------------------------------
// glct_lane
// Crossing machine of one sensor group: records hits and reports a crossing.
// ----------------------------------------------------------------------------
module glct_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             enable,
  input  logic [glct_pkg::GROUP_BITS-1:0]  grp,
  output glct_pkg::lane_step_t             step
);
  import glct_pkg::*;

  phase_t                phase, phase_next;
  logic [GROUP_BITS-1:0] seen, seen_next;
  logic [GROUP_BITS-1:0] merged;
  logic                  abort_hit;

  always_comb begin
    phase_next   = phase;
    seen_next    = seen;
    step.crossed = 1'b0;
    step.back    = 1'b0;
    merged       = seen | grp;
    abort_hit    = 1'b0;
    unique case (phase)
      PH_STANDBY: begin
        if ((grp & EDGE_MASK) != '0) begin
          seen_next  = merged;
          phase_next = PH_BACK;
        end
        if ((grp & MID_MASK) != '0) begin
          seen_next  = merged;
          phase_next = PH_FORWARD;
        end
      end
      PH_FORWARD, PH_BACK: begin
        abort_hit = (phase == PH_FORWARD) ? ((grp & EDGE_MASK) != '0)
                                          : ((grp & MID_MASK) != '0);
        seen_next = merged;
        if (abort_hit && ((merged & INNER_MASK) == '0)) begin
          seen_next  = '0;
          phase_next = PH_STANDBY;
        end else if (merged == FULL_MASK) begin
          seen_next    = '0;
          step.crossed = 1'b1;
          step.back    = (phase == PH_BACK);
          phase_next   = PH_END;
        end
      end
      PH_END: begin
        if (grp == '0) phase_next = PH_STANDBY;
      end
      default: begin
        phase_next = PH_STANDBY;
      end
    endcase
    // disabled lane holds its state and never crosses
    if (!enable) begin
      phase_next   = phase;
      seen_next    = seen;
      step.crossed = 1'b0;
      step.back    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_STANDBY;
      seen  <= '0;
    end else if (advance) begin
      phase <= phase_next;
      seen  <= seen_next;
    end
  end

endmodule

### hw/rtl/glct_merge.sv
// ----------------------------------------------------------------------------
// glct_merge
// Combines lane crossings into net axis steps and keeps saturating positions.
// ----------------------------------------------------------------------------
module glct_merge #(
  parameter int POSITION_BITS = glct_pkg::POSITION_BITS_D
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  glct_pkg::lane_step_t [3:0]         steps,
  output logic [glct_pkg::OUT_POS_BITS-1:0]  x_out,
  output logic [glct_pkg::OUT_POS_BITS-1:0]  y_out,
  output logic [glct_pkg::NUM_GROUPS-1:0]    crossed
);
  import glct_pkg::*;

  localparam int EXT_BITS = POSITION_BITS + 2;
  localparam int REP_BITS = (POSITION_BITS > OUT_POS_BITS) ? POSITION_BITS : OUT_POS_BITS;

  localparam logic signed [EXT_BITS-1:0] POS_MAX =
    EXT_BITS'((64'sd1 <<< (POSITION_BITS - 1)) - 64'sd1);
  localparam logic signed [EXT_BITS-1:0] POS_MIN =
    EXT_BITS'(-(64'sd1 <<< (POSITION_BITS - 1)));

  logic signed [POSITION_BITS-1:0] x_pos, y_pos;
  logic signed [POSITION_BITS-1:0] x_pos_next, y_pos_next;
  logic signed [2:0]               dx, dy;
  logic signed [EXT_BITS-1:0]      x_sum, y_sum;
  logic signed [REP_BITS-1:0]      x_rep, y_rep;

  // forward is +1 for up/right, -1 for down/left
  function automatic logic signed [2:0] lane_delta(input lane_step_t st, input logic invert);
    logic signed [2:0] d;
    d = 3'sd0;
    if (st.crossed) d = (st.back ^ invert) ? -3'sd1 : 3'sd1;
    return d;
  endfunction

  function automatic logic signed [POSITION_BITS-1:0] clamp(input logic signed [EXT_BITS-1:0] v);
    logic signed [POSITION_BITS-1:0] r;
    if (v > POS_MAX)      r = POS_MAX[POSITION_BITS-1:0];
    else if (v < POS_MIN) r = POS_MIN[POSITION_BITS-1:0];
    else                  r = v[POSITION_BITS-1:0];
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_GROUPS; i++) crossed[i] = steps[i].crossed;
    dx = lane_delta(steps[GRP_UP], 1'b0) + lane_delta(steps[GRP_DOWN], 1'b1);
    dy = lane_delta(steps[GRP_RIGHT], 1'b0) + lane_delta(steps[GRP_LEFT], 1'b1);
    x_sum = EXT_BITS'(x_pos) + EXT_BITS'(dx);
    y_sum = EXT_BITS'(y_pos) + EXT_BITS'(dy);
    x_pos_next = clamp(x_sum);
    y_pos_next = clamp(y_sum);
    x_rep = REP_BITS'(x_pos_next);
    y_rep = REP_BITS'(y_pos_next);
    x_out = x_rep[OUT_POS_BITS-1:0];
    y_out = y_rep[OUT_POS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos <= '0;
      y_pos <= '0;
    end else if (advance) begin
      x_pos <= x_pos_next;
      y_pos <= y_pos_next;
    end
  end

endmodule

### hw/rtl/grid_line_crossing_tracker_core.sv
// ----------------------------------------------------------------------------
// grid_line_crossing_tracker_core
// Four parallel group machines, a merge stage and an output skid pair.
// ----------------------------------------------------------------------------
// One sensor sample enters per clock while in_stall is low, and its result is
// registered in the output register, or in the skid entry while the output is
// stalled. The step outputs of the four group lanes and the two saturating
// position adders are combinational ahead of those registers. A two-entry
// output buffer lets one more sample be taken while a result is stalled; input
// stall rises only when both are full. group_enable sits at byte address 0 and may be written only while idle.
module grid_line_crossing_tracker_core #(
  parameter int POSITION_BITS = glct_pkg::POSITION_BITS_D
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [glct_pkg::SAMPLE_BITS-1:0]   sensor_bits,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [glct_pkg::OUT_POS_BITS-1:0]  x_position,
  output logic [glct_pkg::OUT_POS_BITS-1:0]  y_position,
  output logic [glct_pkg::NUM_GROUPS-1:0]    crossed_groups,
  output logic                               sensor_fault
);
  import glct_pkg::*;

  logic [NUM_GROUPS-1:0]            group_enable;
  logic [NUM_GROUPS*GROUP_BITS-1:0] groups;
  lane_step_t [NUM_GROUPS-1:0]      steps;
  result_t                          res_new, res_out, res_skid;
  logic                             skid_valid;
  logic                             in_xfer, out_free;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GROUP_ENABLE) ? {28'd0, group_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_enable <= GROUP_ENABLE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_GROUP_ENABLE)) begin
      group_enable <= pwdata[NUM_GROUPS-1:0];
    end
  end

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign groups   = split_groups(sensor_bits);

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_lane
    glct_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .advance (in_xfer),
      .enable  (group_enable[g]),
      .grp     (groups[g*GROUP_BITS +: GROUP_BITS]),
      .step    (steps[g])
    );
  end

  glct_merge #(
    .POSITION_BITS (POSITION_BITS)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .advance (in_xfer),
    .steps   (steps),
    .x_out   (res_new.x_position),
    .y_out   (res_new.y_position),
    .crossed (res_new.crossed_groups)
  );

  assign res_new.sensor_fault = (sensor_bits == SAMPLE_ZERO) || (sensor_bits == SAMPLE_ONES);

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res_out <= skid_valid ? res_skid : res_new;
    end else if (in_xfer) begin
      res_skid <= res_new;
    end
  end

  assign x_position     = res_out.x_position;
  assign y_position     = res_out.y_position;
  assign crossed_groups = res_out.crossed_groups;
  assign sensor_fault   = res_out.sensor_fault;

endmodule
